/* design/wide_binary_to_decimal_unit_defines.svh */
// Assertion macros shared by the wide binary to decimal unit.
`ifndef WIDE_BINARY_TO_DECIMAL_UNIT_DEFINES_SVH
`define WIDE_BINARY_TO_DECIMAL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define WBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wide_binary_to_decimal_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wide_binary_to_decimal_unit: assertion failed");

`else

`define WBD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/wbd_pkg.sv */
// Shared types and constants of the wide binary to decimal unit.
`timescale 1ns / 1ps
`default_nettype none

package wbd_pkg;

	// Default width of the converted integer.
	localparam int VALUE_WIDTH_DEF = 128;

	// Width of one BCD digit.
	localparam int DIGIT_W = 4;

	// ASCII codes of the emitted characters.
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// Sequencer of the top level.
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_CONV,
		TOP_EMIT
	} top_state_t;

	// Sequencer of the character emitter.
	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SKIP,
		EM_SIGN,
		EM_DIGIT
	} emit_state_t;

	// Command from the top level to the character emitter.
	typedef struct packed {
		logic start;
		logic neg;
	} emit_cmd_t;

endpackage

`default_nettype wire

/* design/wbd_dabble.sv */
// Bit-serial double dabble converter from a binary magnitude to packed BCD.
`timescale 1ns / 1ps
`default_nettype none

module wbd_dabble #(
	parameter int VALUE_WIDTH = wbd_pkg::VALUE_WIDTH_DEF,
	parameter int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [VALUE_WIDTH-1:0]                mag,
	output logic                                       done,
	output logic      [DIGITS*wbd_pkg::DIGIT_W-1:0]    bcd
);

	localparam int DW   = wbd_pkg::DIGIT_W;
	localparam int BcdW = DIGITS * DW;
	localparam int CntW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BcdW-1:0]        bcd_q;
	logic [BcdW-1:0]        adj;
	logic [CntW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// Each digit of five or more gets three added before the shift.
	for (genvar g = 0; g < DIGITS; g++) begin : g_adj
		assign adj[g*DW +: DW] = (bcd_q[g*DW +: DW] >= DW'(5)) ?
			bcd_q[g*DW +: DW] + DW'(3) : bcd_q[g*DW +: DW];
	end

	// Bit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The magnitude shifts out MSB first into the adjusted BCD register.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= bin_q << 1;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

/* design/wbd_emit.sv */
// Character emitter: drops leading zeros and sends the sign and digits as ASCII.
`timescale 1ns / 1ps
`default_nettype none

module wbd_emit #(
	parameter int DIGITS = (wbd_pkg::VALUE_WIDTH_DEF * 30103) / 100000 + 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wbd_pkg::emit_cmd_t                 cmd,
	input  wire logic [DIGITS*wbd_pkg::DIGIT_W-1:0] bcd,
	output logic                                    busy,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [7:0]                         character,
	output logic                                    last_char
);

	localparam int DW   = wbd_pkg::DIGIT_W;
	localparam int BcdW = DIGITS * DW;
	localparam int RemW = $clog2(DIGITS + 1);

	wbd_pkg::emit_state_t state_q;
	wbd_pkg::emit_state_t state_d;

	logic [BcdW-1:0] dig_q;
	logic [RemW-1:0] rem_q;
	logic            neg_q;
	logic [DW-1:0]   top_digit;
	logic            top_zero;
	logic            rem_one;
	logic            shift_en;

	assign top_digit = dig_q[BcdW-1 -: DW];
	assign top_zero  = (top_digit == '0);
	assign rem_one   = (rem_q == RemW'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wbd_pkg::EM_IDLE: begin
				if (cmd.start) begin
					state_d = wbd_pkg::EM_SKIP;
				end
			end
			wbd_pkg::EM_SKIP: begin
				if (!top_zero || rem_one) begin
					state_d = neg_q ? wbd_pkg::EM_SIGN : wbd_pkg::EM_DIGIT;
				end
			end
			wbd_pkg::EM_SIGN: begin
				if (!out_stall) begin
					state_d = wbd_pkg::EM_DIGIT;
				end
			end
			wbd_pkg::EM_DIGIT: begin
				if (!out_stall && rem_one) begin
					state_d = wbd_pkg::EM_IDLE;
				end
			end
			default: begin
				state_d = wbd_pkg::EM_IDLE;
			end
		endcase
	end

	// Outputs and digit shift enable.
	always_comb begin
		out_valid = 1'b0;
		last_char = 1'b0;
		shift_en  = 1'b0;
		character = wbd_pkg::CHAR_ZERO + {{(8-DW){1'b0}}, top_digit};
		unique case (state_q)
			wbd_pkg::EM_IDLE: begin
				shift_en = 1'b0;
			end
			wbd_pkg::EM_SKIP: begin
				shift_en = top_zero && !rem_one;
			end
			wbd_pkg::EM_SIGN: begin
				out_valid = 1'b1;
				character = wbd_pkg::CHAR_MINUS;
			end
			wbd_pkg::EM_DIGIT: begin
				out_valid = 1'b1;
				last_char = rem_one;
				shift_en  = !out_stall;
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	// State and remaining digit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbd_pkg::EM_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				rem_q <= RemW'(DIGITS);
			end else if (shift_en) begin
				rem_q <= rem_q - RemW'(1);
			end
		end
	end

	// Digit shift register, most significant digit at the top.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dig_q <= bcd;
			neg_q <= cmd.neg;
		end else if (shift_en) begin
			dig_q <= {dig_q[BcdW-DW-1:0], {DW{1'b0}}};
		end
	end

	assign busy = (state_q != wbd_pkg::EM_IDLE);

endmodule

`default_nettype wire

/* design/wide_binary_to_decimal_unit.sv */
// Top level of the wide binary to decimal unit.
// Converts one integer of VALUE_WIDTH bits, taken from value_high:value_low and
// read as two's complement when value_signed is set, into its decimal ASCII text,
// most significant character first, with a leading '-' for negative values and
// no leading zeros; last_char marks the final character. One number is handled
// at a time. A number first passes through the bit-serial double dabble shift;
// then leading zero digits are dropped to find the first digit, each character
// is sent, and the unit hands back to the input. The BCD shift takes one bit
// per cycle, and the output shift one digit per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module wide_binary_to_decimal_unit #(
	parameter int VALUE_WIDTH = wbd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] value_low,
	input  wire logic [63:0] value_high,
	input  wire logic        value_signed,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  character,
	output logic             last_char
);

`include "wide_binary_to_decimal_unit_defines.svh"

	localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BcdW   = DIGITS * wbd_pkg::DIGIT_W;

	wbd_pkg::top_state_t state_q;
	wbd_pkg::top_state_t state_d;
	wbd_pkg::emit_cmd_t  emit_cmd;

	logic [127:0]             value_all;
	logic [VALUE_WIDTH-1:0]   value_w;
	logic [VALUE_WIDTH-1:0]   mag;
	logic                     neg;
	logic                     neg_q;
	logic                     conv_start;
	logic                     conv_done;
	logic [BcdW-1:0]          bcd;
	logic                     emit_busy;

	// Magnitude of the incoming value; bits above the width are ignored.
	assign value_all = {value_high, value_low};
	assign value_w   = value_all[VALUE_WIDTH-1:0];
	assign neg       = value_signed && value_w[VALUE_WIDTH-1];
	assign mag       = neg ? (~value_w + VALUE_WIDTH'(1)) : value_w;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wbd_pkg::TOP_IDLE: begin
				if (in_valid) begin
					state_d = wbd_pkg::TOP_CONV;
				end
			end
			wbd_pkg::TOP_CONV: begin
				if (conv_done) begin
					state_d = wbd_pkg::TOP_EMIT;
				end
			end
			wbd_pkg::TOP_EMIT: begin
				if (!emit_busy) begin
					state_d = wbd_pkg::TOP_IDLE;
				end
			end
			default: begin
				state_d = wbd_pkg::TOP_IDLE;
			end
		endcase
	end

	// Handshake and unit start signals.
	always_comb begin
		in_stall       = 1'b1;
		conv_start     = 1'b0;
		emit_cmd.start = 1'b0;
		emit_cmd.neg   = neg_q;
		unique case (state_q)
			wbd_pkg::TOP_IDLE: begin
				in_stall   = 1'b0;
				conv_start = in_valid;
			end
			wbd_pkg::TOP_CONV: begin
				emit_cmd.start = conv_done;
			end
			wbd_pkg::TOP_EMIT: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbd_pkg::TOP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sign of the accepted transaction, held for the emitter.
	always_ff @(posedge clk) begin
		if (conv_start) begin
			neg_q <= neg;
		end
	end

	wbd_dabble #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGITS      (DIGITS)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	wbd_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (emit_cmd),
		.bcd       (bcd),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last_char (last_char)
	);

	// Characters are only offered while the sequencer is in its emit phase.
	`WBD_ASSERT_SAME(a_out_in_emit, clk, arst_n, out_valid, state_q == wbd_pkg::TOP_EMIT)
	// The conversion finishes only while the sequencer waits for it.
	`WBD_ASSERT_SAME(a_done_in_conv, clk, arst_n, conv_done, state_q == wbd_pkg::TOP_CONV)
	// No new transaction is taken while characters are still pending.
	`WBD_ASSERT_SAME(a_stall_busy, clk, arst_n, emit_busy, in_stall)
	// Nothing follows the last character of a number.
	`WBD_ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && !out_stall && last_char, !out_valid)

endmodule

`default_nettype wire

/* verif/decimal_text_checker.sv */
// Checker that predicts and compares the decimal text produced by the conversion unit.
`timescale 1ns / 1ps

module decimal_text_checker #(
	parameter int VALUE_WIDTH = wbd_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] value_low,
	input  logic [63:0] value_high,
	input  logic        value_signed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  character,
	input  logic        last_char,
	output int          fail_count,
	output int          chars_pending,
	output int          numbers_checked
);

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} text_char_t;

	// Characters still owed by the unit, oldest first.
	text_char_t expected_text[$];

	// Append the decimal text of one number to the expected characters.
	task automatic predict_text(input logic [63:0] lo, input logic [63:0] hi,
			input logic is_signed);
		logic [127:0] width_mask;
		logic [127:0] magnitude;
		logic [3:0]   digit_buf [40];
		logic         negative;
		int           n_digits;
		int           k;
		text_char_t   entry;
		width_mask = (VALUE_WIDTH >= 128) ? '1 : ((128'd1 << VALUE_WIDTH) - 128'd1);
		magnitude = {hi, lo} & width_mask;
		negative = is_signed && magnitude[VALUE_WIDTH-1];
		// The most negative value negates to its own bit pattern, which read
		// unsigned is exactly the magnitude wanted.
		if (negative) begin
			magnitude = (~magnitude + 128'd1) & width_mask;
		end
		n_digits = 0;
		do begin
			digit_buf[n_digits] = 4'(magnitude % 128'd10);
			magnitude = magnitude / 128'd10;
			n_digits++;
		end while (magnitude != 128'd0 && n_digits < 40);
		if (negative) begin
			entry.character = wbd_pkg::CHAR_MINUS;
			entry.last_char = 1'b0;
			expected_text = {expected_text, entry};
		end
		for (k = n_digits - 1; k >= 0; k--) begin
			entry.character = wbd_pkg::CHAR_ZERO + 8'(digit_buf[k]);
			entry.last_char = (k == 0);
			expected_text = {expected_text, entry};
		end
	endtask

	initial begin
		fail_count = 0;
		chars_pending = 0;
		numbers_checked = 0;
	end

	// Both channels are sampled at the rising edge, before the driven values move.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_text(value_low, value_high, value_signed);
			end
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					$error("character: no transaction expected, actual %0d", character);
					fail_count++;
				end else begin
					want = expected_text.pop_front();
					if (character !== want.character) begin
						$error("character: expected %0d, actual %0d",
							want.character, character);
						fail_count++;
					end
					if (last_char !== want.last_char) begin
						$error("last_char: expected %0d, actual %0d",
							want.last_char, last_char);
						fail_count++;
					end
					if (want.last_char) begin
						numbers_checked++;
					end
				end
			end
			chars_pending = expected_text.size();
		end
	end

endmodule

/* verif/tb.sv */
// Testbench top that drives numbers into the conversion unit and reports the verdict.
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_ITEMS     = 90;
	localparam int QUIET_ITEMS      = 20;
	localparam int LONG_HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES     = 200;
	localparam int CYCLE_LIMIT      = 500000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value_low;
	logic [63:0] value_high;
	logic        value_signed;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  character;
	logic        last_char;

	int fail_count;
	int chars_pending;
	int numbers_checked;
	int numbers_sent = 0;
	int cycle_count = 0;
	bit hold_due = 1'b0;
	bit quiet = 1'b0;

	wide_binary_to_decimal_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value_low    (value_low),
		.value_high   (value_high),
		.value_signed (value_signed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.character    (character),
		.last_char    (last_char)
	);

	decimal_text_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.value_low       (value_low),
		.value_high      (value_high),
		.value_signed    (value_signed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.character       (character),
		.last_char       (last_char),
		.fail_count      (fail_count),
		.chars_pending   (chars_pending),
		.numbers_checked (numbers_checked)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offer one number and hold it until the unit takes the transaction.
	task automatic send_number(input logic [127:0] number, input logic is_signed);
		int gap;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value_low <= number[63:0];
		value_high <= number[127:64];
		value_signed <= is_signed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		numbers_sent++;
	endtask

	// Output side: random stall bursts, one long hold-off, then no stalls at the end.
	initial begin : receiver
		int burst;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_due) begin
				hold_due = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				burst = $urandom_range(1, 19);
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (burst - 1) @(posedge clk);
			end
		end
	end

	// Stimulus: directed corner numbers first, then random numbers of several shapes.
	initial begin : stimulus
		logic [127:0] number;
		int           k;
		int           kind;
		int           n_bits;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value_low <= '0;
		value_high <= '0;
		value_signed <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, one, all ones and the signed extremes.
		send_number(128'd0, 1'b0);
		send_number(128'd0, 1'b1);
		send_number(128'd1, 1'b0);
		send_number('1, 1'b0);
		send_number('1, 1'b1);
		send_number({1'b1, 127'd0}, 1'b1);
		send_number({1'b1, 127'd0}, 1'b0);
		send_number({1'b0, {127{1'b1}}}, 1'b1);
		send_number({64'd0, {64{1'b1}}}, 1'b0);
		send_number({64'd1, 64'd0}, 1'b1);
		send_number(~128'd10 + 128'd1, 1'b1);
		// The low half's top bit is not a sign bit at this width.
		send_number({64'd0, 1'b1, 63'd0}, 1'b1);

		// Digit count boundaries: 9 and 10, 99 and 100, and larger powers of ten.
		number = 128'd1;
		for (k = 1; k <= 38; k++) begin
			number = number * 128'd10;
			if (k inside {1, 2, 19, 38}) begin
				send_number(number - 128'd1, 1'b0);
				send_number(number, 1'b0);
			end
		end

		hold_due = 1'b1;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k >= RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet = 1'b1;
			end
			kind = $urandom_range(0, 4);
			case (kind)
				0: begin
					number = {$urandom, $urandom, $urandom, $urandom};
				end
				1: begin
					n_bits = $urandom_range(1, 64);
					number = {64'd0, {$urandom, $urandom} >> (64 - n_bits)};
				end
				2: begin
					number = {96'd0, $urandom};
					number = ~number + 128'd1;
				end
				3: begin
					n_bits = $urandom_range(1, 64);
					number = {{$urandom, $urandom} >> (64 - n_bits), $urandom, $urandom};
				end
				default: begin
					number = 128'd1;
					repeat ($urandom_range(0, 38)) number = number * 128'd10;
					number = number + 128'($urandom_range(0, 2)) - 128'd1;
					if ($urandom_range(0, 1) == 1) begin
						number = ~number + 128'd1;
					end
				end
			endcase
			send_number(number, 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;

		// One more edge so the checker has counted the last transaction.
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d numbers and checked %0d complete texts, covering zero, both signs,",
			numbers_sent, numbers_checked);
		$display("the signed and unsigned extremes, power-of-ten boundaries and random values.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/wbd_pkg.sv
design/wbd_dabble.sv
design/wbd_emit.sv
design/wide_binary_to_decimal_unit.sv
verif/decimal_text_checker.sv
verif/tb.sv
